### src/twmm_pkg.sv
// ----------------------------------------------------------------------------
// twmm_pkg
// Shared types, register codes and defaults of the time window min/max unit.
// ----------------------------------------------------------------------------
package twmm_pkg;

    // default geometry
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int WINDOW_DEPTH_DEF = 16;

    // field widths
    localparam int CHAN_W  = 3;
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 16;
    localparam int DUR_W   = 32;
    localparam int CIU_W   = 4;
    localparam int CFG_W   = 32;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_DURATION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS_IN_USE = 1'b1;

    // register reset values
    localparam logic [DUR_W-1:0] DUR_RESET = 32'd1000;
    localparam logic [CIU_W-1:0] CIU_RESET = 4'd8;

    // one stored sample with its valid mark
    typedef struct packed {
        logic               valid;
        logic [TIME_W-1:0]  stamp;
        logic [VALUE_W-1:0] value;
    } twmm_entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXPIRE,
        ST_STORE_RD,
        ST_STORE_WR,
        ST_REPORT,
        ST_EMIT
    } twmm_state_t;

endpackage

### src/twmm_ram.sv
// ----------------------------------------------------------------------------
// twmm_ram
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module twmm_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  twmm_pkg::twmm_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output twmm_pkg::twmm_entry_t rd_data
);

    twmm_pkg::twmm_entry_t mem [DEPTH];
    twmm_pkg::twmm_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/time_window_min_max_unit.sv
// ----------------------------------------------------------------------------
// time_window_min_max_unit
// Per-channel sliding time window with minimum and maximum report.
// ----------------------------------------------------------------------------
// flow: a sample is accepted in idle and stored through ST_STORE_RD and ST_STORE_WR;
//   a record's first sample first runs an expiry scan over all stored entries,
//   its last sample then adds a report pass per reported channel plus out stall
// input: stalled while the sequencer runs, so no new sample until idle again; an
//   unmarked sample on a channel out of use is dropped without leaving idle
// reset: clearing pass over every stored entry, input stalled meanwhile
module time_window_min_max_unit #(
    parameter int NUM_CHANNELS = twmm_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW_DEPTH = twmm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [twmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [twmm_pkg::CFG_W-1:0]          cfg_data,
    // sample input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [twmm_pkg::CHAN_W-1:0]         channel,
    input  logic [twmm_pkg::TIME_W-1:0]         sample_time,
    input  logic signed [twmm_pkg::VALUE_W-1:0] sample_value,
    input  logic                                first_in_record,
    input  logic                                last_in_record,
    // report output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [twmm_pkg::CHAN_W-1:0]         report_channel,
    output logic signed [twmm_pkg::VALUE_W-1:0] window_min,
    output logic signed [twmm_pkg::VALUE_W-1:0] window_max,
    output logic                                has_values,
    output logic                                overflowed,
    output logic                                last_result
);

    localparam int TOTAL = NUM_CHANNELS * WINDOW_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int CNTW  = $clog2(TOTAL + 1);
    localparam int CW    = $clog2(NUM_CHANNELS);
    localparam int SW    = $clog2(WINDOW_DEPTH);
    localparam int KW    = $clog2(WINDOW_DEPTH + 1);
    localparam int NW    = $clog2(NUM_CHANNELS + 1);
    localparam int XW    = (NW > twmm_pkg::CIU_W) ? NW : twmm_pkg::CIU_W;
    localparam int VW    = twmm_pkg::VALUE_W;
    localparam int TW    = twmm_pkg::TIME_W;

    // control registers
    twmm_pkg::twmm_state_t state_reg, state_next;
    logic [CNTW-1:0]             cnt_reg, cnt_next;
    logic [KW-1:0]               k_reg, k_next;
    logic                        pend_reg, pend_next;
    logic [NW-1:0]               rep_ch_reg, rep_ch_next;
    logic                        any_reg, any_next;
    logic [SW-1:0]               slot_reg [NUM_CHANNELS];
    logic [SW-1:0]               slot_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]     ovf_reg, ovf_next;
    logic [twmm_pkg::DUR_W-1:0]  dur_reg, dur_next;
    logic [twmm_pkg::CIU_W-1:0]  ciu_reg, ciu_next;
    logic                        out_valid_reg, out_valid_next;

    // payload registers
    logic [AW-1:0]               pend_addr_reg, pend_addr_next;
    logic [twmm_pkg::CHAN_W-1:0] ch_reg, ch_next;
    logic [TW-1:0]               time_reg, time_next;
    logic [VW-1:0]               value_reg, value_next;
    logic                        last_reg, last_next;
    logic signed [VW-1:0]        mn_reg, mn_next;
    logic signed [VW-1:0]        mx_reg, mx_next;
    logic [twmm_pkg::CHAN_W-1:0] rc_reg, rc_next;
    logic signed [VW-1:0]        wmin_reg, wmin_next;
    logic signed [VW-1:0]        wmax_reg, wmax_next;
    logic                        hv_reg, hv_next;
    logic                        ovo_reg, ovo_next;
    logic                        lr_reg, lr_next;

    // store ports
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    twmm_pkg::twmm_entry_t rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    twmm_pkg::twmm_entry_t wr_data;

    // derived values
    logic [NW-1:0]        act;
    logic [CW-1:0]        ch_idx;
    logic [CW-1:0]        rep_idx;
    logic                 ch_in_use;
    logic                 in_ch_in_use;
    logic                 rep_go;
    logic [AW-1:0]        store_addr;
    logic                 expired;
    logic signed [VW-1:0] rd_value;
    logic                 lt_min;
    logic                 gt_max;

    twmm_ram #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // active channel count, clamped to the channel capacity
    always_comb
    begin
        if (XW'(ciu_reg) > XW'(NUM_CHANNELS))
        begin
            act = NW'(NUM_CHANNELS);
        end
        else
        begin
            act = NW'(ciu_reg);
        end
    end

    assign ch_idx       = CW'(ch_reg);
    assign rep_idx      = CW'(rep_ch_reg);
    assign ch_in_use    = XW'(ch_reg) < XW'(act);
    assign in_ch_in_use = XW'(channel) < XW'(act);
    assign rep_go       = last_reg && (act != '0);
    assign store_addr   = AW'(ch_idx) * AW'(WINDOW_DEPTH) + AW'(slot_reg[ch_idx]);

    // shared compare unit: expiry test and running min/max update
    assign expired  = ({1'b0, rd_data.stamp} + {1'b0, dur_reg}) < {1'b0, time_reg};
    assign rd_value = $signed(rd_data.value);
    assign lt_min   = rd_value < mn_reg;
    assign gt_max   = rd_value > mx_reg;

    // sequencer next state and datapath control
    always_comb
    begin
        logic go_rep;
        go_rep         = 1'b0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rep_ch_next    = rep_ch_reg;
        any_next       = any_reg;
        slot_next      = slot_reg;
        ovf_next       = ovf_reg;
        dur_next       = dur_reg;
        ciu_next       = ciu_reg;
        ch_next        = ch_reg;
        time_next      = time_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        rc_next        = rc_reg;
        wmin_next      = wmin_reg;
        wmax_next      = wmax_reg;
        hv_next        = hv_reg;
        ovo_next       = ovo_reg;
        lr_next        = lr_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;
        wr_data.valid  = 1'b0;

        // output register drains on a transfer
        out_valid_next = out_valid_reg && out_stall;

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                twmm_pkg::REG_WINDOW_DURATION: dur_next = cfg_data;
                twmm_pkg::REG_CHANNELS_IN_USE: ciu_next = cfg_data[twmm_pkg::CIU_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            twmm_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_data = '0;
                if (cnt_reg == CNTW'(TOTAL - 1))
                begin
                    cnt_next   = '0;
                    state_next = twmm_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end

            twmm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = channel;
                    time_next  = sample_time;
                    value_next = sample_value;
                    last_next  = last_in_record;
                    if (first_in_record)
                    begin
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        state_next = twmm_pkg::ST_EXPIRE;
                    end
                    else if (in_ch_in_use)
                    begin
                        state_next = twmm_pkg::ST_STORE_RD;
                    end
                    else if (last_in_record && (act != '0))
                    begin
                        go_rep = 1'b1;
                    end
                end
            end

            twmm_pkg::ST_EXPIRE:
            begin
                // issue one read a cycle, retire the previous one
                pend_next = 1'b0;
                if (cnt_reg != CNTW'(TOTAL))
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[AW-1:0];
                    cnt_next       = cnt_reg + CNTW'(1);
                end
                if (pend_reg && rd_data.valid && expired)
                begin
                    wr_en = 1'b1;
                end
                if (cnt_reg == CNTW'(TOTAL))
                begin
                    if (ch_in_use)
                    begin
                        state_next = twmm_pkg::ST_STORE_RD;
                    end
                    else if (rep_go)
                    begin
                        go_rep = 1'b1;
                    end
                    else
                    begin
                        state_next = twmm_pkg::ST_IDLE;
                    end
                end
            end

            twmm_pkg::ST_STORE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = store_addr;
                state_next = twmm_pkg::ST_STORE_WR;
            end

            twmm_pkg::ST_STORE_WR:
            begin
                wr_en         = 1'b1;
                wr_addr       = store_addr;
                wr_data.valid = 1'b1;
                wr_data.stamp = time_reg;
                wr_data.value = value_reg;
                // overwriting a live entry marks the ring as overflowed
                if (rd_data.valid)
                begin
                    ovf_next[ch_idx] = 1'b1;
                end
                if (slot_reg[ch_idx] == SW'(WINDOW_DEPTH - 1))
                begin
                    slot_next[ch_idx] = '0;
                end
                else
                begin
                    slot_next[ch_idx] = slot_reg[ch_idx] + SW'(1);
                end
                if (rep_go)
                begin
                    go_rep = 1'b1;
                end
                else
                begin
                    state_next = twmm_pkg::ST_IDLE;
                end
            end

            twmm_pkg::ST_REPORT:
            begin
                pend_next = 1'b0;
                if (k_reg != KW'(WINDOW_DEPTH))
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CNTW'(1);
                    k_next    = k_reg + KW'(1);
                end
                // running min/max over valid entries
                if (pend_reg && rd_data.valid)
                begin
                    any_next = 1'b1;
                    if (!any_reg || lt_min)
                    begin
                        mn_next = rd_value;
                    end
                    if (!any_reg || gt_max)
                    begin
                        mx_next = rd_value;
                    end
                end
                if (k_reg == KW'(WINDOW_DEPTH))
                begin
                    state_next = twmm_pkg::ST_EMIT;
                end
            end

            twmm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    rc_next           = twmm_pkg::CHAN_W'(rep_ch_reg);
                    wmin_next         = any_reg ? mn_reg : '0;
                    wmax_next         = any_reg ? mx_reg : '0;
                    hv_next           = any_reg;
                    ovo_next          = ovf_reg[rep_idx];
                    lr_next           = (rep_ch_reg + NW'(1)) == act;
                    ovf_next[rep_idx] = 1'b0;
                    any_next          = 1'b0;
                    k_next            = '0;
                    if ((rep_ch_reg + NW'(1)) == act)
                    begin
                        state_next = twmm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rep_ch_next = rep_ch_reg + NW'(1);
                        state_next  = twmm_pkg::ST_REPORT;
                    end
                end
            end

            default:
            begin
                state_next = twmm_pkg::ST_IDLE;
            end
        endcase

        // report start: channel 0, store address 0
        if (go_rep)
        begin
            state_next  = twmm_pkg::ST_REPORT;
            cnt_next    = '0;
            k_next      = '0;
            rep_ch_next = '0;
            any_next    = 1'b0;
            pend_next   = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twmm_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            rep_ch_reg    <= '0;
            any_reg       <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                slot_reg[i] <= '0;
            end
            ovf_reg       <= '0;
            dur_reg       <= twmm_pkg::DUR_RESET;
            ciu_reg       <= twmm_pkg::CIU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            rep_ch_reg    <= rep_ch_next;
            any_reg       <= any_next;
            slot_reg      <= slot_next;
            ovf_reg       <= ovf_next;
            dur_reg       <= dur_next;
            ciu_reg       <= ciu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        ch_reg        <= ch_next;
        time_reg      <= time_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        rc_reg        <= rc_next;
        wmin_reg      <= wmin_next;
        wmax_reg      <= wmax_next;
        hv_reg        <= hv_next;
        ovo_reg       <= ovo_next;
        lr_reg        <= lr_next;
    end

    // ports
    assign in_stall       = (state_reg != twmm_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign report_channel = rc_reg;
    assign window_min     = wmin_reg;
    assign window_max     = wmax_reg;
    assign has_values     = hv_reg;
    assign overflowed     = ovo_reg;
    assign last_result    = lr_reg;

endmodule
